// ----- src/mpwm_pkg.sv -----
// package for the multi-pattern wildcard matcher: sizes, character codes,
// command codes, beat types and character helpers; no dependencies
`timescale 1ns / 1ps

package mpwm_pkg;

  localparam int PATTERN_SLOTS   = 8;
  localparam int MAX_PATTERN_LEN = 63;
  localparam int CHAR_BITS       = 16;
  localparam int POS_W           = MAX_PATTERN_LEN + 1;
  localparam int LEN_W           = $clog2(POS_W);
  localparam int SLOT_W          = 3;
  localparam int IN_CHAR_W       = 16;

  localparam logic [CHAR_BITS-1:0] CH_QUESTION  = CHAR_BITS'(8'h3F);
  localparam logic [CHAR_BITS-1:0] CH_STAR      = CHAR_BITS'(8'h2A);
  localparam logic [CHAR_BITS-1:0] CH_SLASH     = CHAR_BITS'(8'h2F);
  localparam logic [CHAR_BITS-1:0] CH_BACKSLASH = CHAR_BITS'(8'h5C);
  localparam logic [CHAR_BITS-1:0] CH_UPPER_A   = CHAR_BITS'(8'h41);
  localparam logic [CHAR_BITS-1:0] CH_UPPER_Z   = CHAR_BITS'(8'h5A);
  localparam logic [CHAR_BITS-1:0] CASE_OFFSET  = CHAR_BITS'(8'h20);

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_PATH   = 2'd2,
    CMD_END    = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic [SLOT_W-1:0]    slot;
    logic [IN_CHAR_W-1:0] char_value;
  } item_t;

  typedef struct packed {
    logic              matched;
    logic [SLOT_W-1:0] match_slot;
    logic              truncated;
  } result_t;

  // classified beat handed from front to engine
  typedef struct packed {
    cmd_e                 cmd;
    logic [SLOT_W-1:0]    slot;
    logic [CHAR_BITS-1:0] ch;
    logic                 is_star;
    logic                 is_any;
  } op_t;

  function automatic logic [CHAR_BITS-1:0] to_char(input logic [IN_CHAR_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[CHAR_BITS-1:0];
  endfunction

  function automatic logic [CHAR_BITS-1:0] fold(input logic [CHAR_BITS-1:0] c);
    logic [CHAR_BITS-1:0] r;
    r = c;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

// ----- src/mpwm_front.sv -----
// front end of the matcher: decodes and classifies incoming beats and
// holds them in a two-entry queue for the engine; uses mpwm_pkg
`timescale 1ns / 1ps

module mpwm_front import mpwm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push,
  output logic  full,
  input  item_t item_i,
  output logic  op_valid_o,
  output op_t   op_o,
  input  logic  op_take_i
);

  op_t             cls;
  op_t             slot_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            push_ok;
  logic            pop_ok;
  logic [CHAR_BITS-1:0] raw_c;
  logic [CHAR_BITS-1:0] pat_c;

  always_comb begin
    raw_c       = to_char(item_i.char_value);
    pat_c       = (raw_c == CH_SLASH) ? CH_BACKSLASH : raw_c;
    cls.cmd     = item_i.cmd;
    cls.slot    = item_i.slot;
    cls.ch      = fold((item_i.cmd == CMD_APPEND) ? pat_c : raw_c);
    cls.is_star = (pat_c == CH_STAR);
    cls.is_any  = (pat_c == CH_QUESTION);
  end

  assign full       = (cnt_q == 2'd2);
  assign push_ok    = push && !full;
  assign op_valid_o = (cnt_q != 2'd0);
  assign pop_ok     = op_take_i && op_valid_o;
  assign op_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_ok ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_ok ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_ok) - 2'(pop_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      slot_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ----- src/mpwm_engine.sv -----
// matching engine: pattern cells, per-slot position sets with star closure,
// end-of-path evaluation and a two-entry result queue; uses mpwm_pkg
`timescale 1ns / 1ps

module mpwm_engine import mpwm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    op_valid_i,
  input  op_t     op_i,
  output logic    op_take_o,
  output logic    empty,
  input  logic    pop,
  output result_t result_o
);

  logic [CHAR_BITS-1:0]       chr_q  [PATTERN_SLOTS][MAX_PATTERN_LEN];
  logic [MAX_PATTERN_LEN-1:0] star_q [PATTERN_SLOTS];
  logic [MAX_PATTERN_LEN-1:0] any_q  [PATTERN_SLOTS];
  logic [LEN_W-1:0]           len_q  [PATTERN_SLOTS];
  logic [LEN_W-1:0]           len_d  [PATTERN_SLOTS];
  logic [POS_W-1:0]           act_q  [PATTERN_SLOTS];
  logic [POS_W-1:0]           act_d  [PATTERN_SLOTS];
  logic                       trunc_q, trunc_d;

  logic [POS_W-1:0]           step_v [PATTERN_SLOTS];
  logic [POS_W-1:0]           prop_v [PATTERN_SLOTS];
  logic [POS_W-1:0]           clos_v [PATTERN_SLOTS];
  logic [PATTERN_SLOTS-1:0]   hit_v;
  logic [PATTERN_SLOTS-1:0]   wr_en;

  result_t                    res_d;
  result_t                    rq_q [2];
  logic                       rq_wr_q, rq_wr_d;
  logic                       rq_rd_q, rq_rd_d;
  logic [1:0]                 rq_cnt_q, rq_cnt_d;
  logic                       rq_push;
  logic                       rq_pop;
  logic                       rq_room;
  logic [SLOT_W-1:0]          which;

  // next position sets, then star closure as a prefix carry chain
  always_comb begin
    logic [POS_W-1:0] g;
    logic [POS_W-1:0] p;
    for (int s = 0; s < PATTERN_SLOTS; s++) begin
      step_v[s] = '0;
      prop_v[s] = '0;
      for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
        if (i < int'(len_q[s])) begin
          prop_v[s][i+1] = star_q[s][i];
          if (act_q[s][i]) begin
            if (star_q[s][i]) begin
              step_v[s][i] = 1'b1;
            end else if (any_q[s][i] || chr_q[s][i] == op_i.ch) begin
              step_v[s][i+1] = 1'b1;
            end
          end
        end
      end
      g = (op_i.cmd == CMD_PATH) ? step_v[s] : POS_W'(1);
      p = prop_v[s];
      for (int d = 1; d < POS_W; d = d * 2) begin
        g = g | (p & (g << d));
        p = p & (p << d);
      end
      clos_v[s] = g;
      hit_v[s]  = (len_q[s] != '0) && act_q[s][len_q[s]];
    end
  end

  always_comb begin
    which = '0;
    for (int s = PATTERN_SLOTS - 1; s >= 0; s--) begin
      if (hit_v[s]) begin
        which = SLOT_W'(s);
      end
    end
    res_d.matched    = |hit_v;
    res_d.match_slot = which;
    res_d.truncated  = trunc_q;
  end

  assign rq_pop    = pop && !empty;
  assign rq_room   = (rq_cnt_q != 2'd2) || rq_pop;
  assign op_take_o = op_valid_i && ((op_i.cmd != CMD_END) || rq_room);
  assign rq_push   = op_take_o && (op_i.cmd == CMD_END);

  always_comb begin
    len_d   = len_q;
    act_d   = act_q;
    trunc_d = trunc_q;
    wr_en   = '0;
    if (op_take_o) begin
      unique case (op_i.cmd)
        CMD_CLEAR: begin
          for (int s = 0; s < PATTERN_SLOTS; s++) begin
            len_d[s] = '0;
            act_d[s] = POS_W'(1);
          end
          trunc_d = 1'b0;
        end
        CMD_APPEND: begin
          for (int s = 0; s < PATTERN_SLOTS; s++) begin
            if (int'(op_i.slot) == s) begin
              if (len_q[s] == LEN_W'(MAX_PATTERN_LEN)) begin
                trunc_d = 1'b1;
              end else begin
                wr_en[s] = 1'b1;
                len_d[s] = len_q[s] + LEN_W'(1);
                if (op_i.is_star && act_q[s][len_q[s]]) begin
                  act_d[s][len_q[s] + LEN_W'(1)] = 1'b1;
                end
              end
            end
          end
        end
        CMD_PATH, CMD_END: begin
          for (int s = 0; s < PATTERN_SLOTS; s++) begin
            act_d[s] = clos_v[s];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < PATTERN_SLOTS; s++) begin
        len_q[s] <= '0;
        act_q[s] <= POS_W'(1);
      end
      trunc_q <= 1'b0;
    end else begin
      len_q   <= len_d;
      act_q   <= act_d;
      trunc_q <= trunc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < PATTERN_SLOTS; s++) begin
      for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
        if (wr_en[s] && i == int'(len_q[s])) begin
          chr_q[s][i]  <= op_i.ch;
          star_q[s][i] <= op_i.is_star;
          any_q[s][i]  <= op_i.is_any;
        end
      end
    end
  end

  // result queue
  assign empty    = (rq_cnt_q == 2'd0);
  assign result_o = rq_q[rq_rd_q];

  always_comb begin
    rq_wr_d  = rq_push ? !rq_wr_q : rq_wr_q;
    rq_rd_d  = rq_pop ? !rq_rd_q : rq_rd_q;
    rq_cnt_d = rq_cnt_q + 2'(rq_push) - 2'(rq_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wr_q  <= 1'b0;
      rq_rd_q  <= 1'b0;
      rq_cnt_q <= 2'd0;
    end else begin
      rq_wr_q  <= rq_wr_d;
      rq_rd_q  <= rq_rd_d;
      rq_cnt_q <= rq_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rq_push) begin
      rq_q[rq_wr_q] <= res_d;
    end
  end

endmodule

// ----- src/multi_pattern_wildcard_matcher.sv -----
// top level of the multi-pattern wildcard matcher
// instantiates mpwm_front and mpwm_engine; uses mpwm_pkg
`timescale 1ns / 1ps

// Takes one beat per clock while full is low: clear, append a pattern
// character to a slot, a path character, or end of path. Accepted beats
// are registered in the two-entry input queue for the engine. A path
// character updates the position sets of all slots in the cycle the
// engine takes it, so the sustained rate is one beat per cycle while no
// end-of-path beat is held. An end-of-path beat's result is registered in
// the result queue, whose head shows on the result ports. The engine holds
// end-of-path beats only while the two-entry result queue is full and not
// being popped. While it holds them, the input queue fills and raises full.

module multi_pattern_wildcard_matcher import mpwm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push,
  output logic    full,
  input  item_t   item_i,
  output logic    empty,
  input  logic    pop,
  output result_t result_o
);

  logic op_valid;
  op_t  op;
  logic op_take;

  mpwm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .item_i     (item_i),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_take_i  (op_take)
  );

  mpwm_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_i       (op),
    .op_take_o  (op_take),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o)
  );

endmodule

// ----- tb/tb_multi_pattern_wildcard_matcher.sv -----
// self-checking testbench for multi_pattern_wildcard_matcher: queue-fed driver, popping monitor
// and a glob predictor that tracks pattern slots and live prefix sets per beat
// depends on mpwm_pkg and the matcher rtl
`timescale 1ns / 1ps

module tb_multi_pattern_wildcard_matcher;
  import mpwm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 375;

  logic    clk_i    = 1'b0;
  logic    rst_ni   = 1'b0;
  logic    push     = 1'b0;
  item_t   item_i   = '0;
  logic    pop      = 1'b0;
  logic    full;
  logic    empty;
  result_t result_o;

  item_t   stim_items[$];
  result_t expected_verdicts[$];
  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;
  int      fail_count     = 0;
  int      cycle_count    = 0;
  int      items_added    = 0;

  logic [CHAR_BITS-1:0] pattern_store [PATTERN_SLOTS][MAX_PATTERN_LEN];
  int                   slot_len      [PATTERN_SLOTS] = '{default: 0};
  logic [POS_W-1:0]     live_prefixes [PATTERN_SLOTS] = '{default: 1};
  logic                 trunc_seen    = 1'b0;

  multi_pattern_wildcard_matcher i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item_i),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [CHAR_BITS-1:0] ascii_lower(input logic [CHAR_BITS-1:0] c);
    logic [CHAR_BITS-1:0] r;
    r = c;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) r = c | CASE_OFFSET;
    return r;
  endfunction

  // prefixes reachable by letting a star match nothing
  function automatic logic [POS_W-1:0] star_reach(input int s, input logic [POS_W-1:0] set);
    logic [POS_W-1:0] r;
    r = set;
    for (int i = 0; i < slot_len[s]; i++) begin
      if (r[i] && pattern_store[s][i] == CH_STAR) r[i+1] = 1'b1;
    end
    return r;
  endfunction

  task automatic apply_beat_to_patterns(input item_t it);
    logic [POS_W-1:0]     cur;
    logic [POS_W-1:0]     nxt;
    logic [CHAR_BITS-1:0] c;
    logic [CHAR_BITS-1:0] pc;
    result_t              v;
    logic                 hit;
    c = it.char_value[CHAR_BITS-1:0];
    case (it.cmd)
      CMD_CLEAR: begin
        for (int s = 0; s < PATTERN_SLOTS; s++) begin
          slot_len[s]      = 0;
          live_prefixes[s] = POS_W'(1);
        end
        trunc_seen = 1'b0;
      end
      CMD_APPEND: begin
        if (slot_len[it.slot] >= MAX_PATTERN_LEN) begin
          trunc_seen = 1'b1;
        end else begin
          if (c == CH_SLASH) c = CH_BACKSLASH;
          pattern_store[it.slot][slot_len[it.slot]] = c;
          slot_len[it.slot]++;
        end
      end
      CMD_PATH: begin
        for (int s = 0; s < PATTERN_SLOTS; s++) begin
          cur = star_reach(s, live_prefixes[s]);
          nxt = '0;
          for (int i = 0; i < slot_len[s]; i++) begin
            pc = pattern_store[s][i];
            if (cur[i]) begin
              if (pc == CH_STAR) nxt[i] = 1'b1;
              else if (pc == CH_QUESTION || ascii_lower(pc) == ascii_lower(c)) nxt[i+1] = 1'b1;
            end
          end
          live_prefixes[s] = nxt;
        end
      end
      CMD_END: begin
        v   = '0;
        hit = 1'b0;
        for (int s = 0; s < PATTERN_SLOTS; s++) begin
          if (!hit && slot_len[s] != 0) begin
            cur = star_reach(s, live_prefixes[s]);
            if (cur[slot_len[s]]) begin
              hit          = 1'b1;
              v.matched    = 1'b1;
              v.match_slot = SLOT_W'(s);
            end
          end
        end
        v.truncated = trunc_seen;
        expected_verdicts = {expected_verdicts, v};
        for (int s = 0; s < PATTERN_SLOTS; s++) live_prefixes[s] = POS_W'(1);
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push   <= 1'b0;
      item_i <= '0;
    end else begin
      if (push && !full) apply_beat_to_patterns(item_i);
      if (!push || !full) begin
        if (stim_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push   <= 1'b1;
          item_i <= stim_items.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected result beat: matched %0d match_slot %0d truncated %0d",
                 result_o.matched, result_o.match_slot, result_o.truncated);
          fail_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (result_o.matched !== want.matched) begin
            $error("matched: expected %0d, got %0d", want.matched, result_o.matched);
            fail_count++;
          end
          if (result_o.match_slot !== want.match_slot) begin
            $error("match_slot: expected %0d, got %0d", want.match_slot, result_o.match_slot);
            fail_count++;
          end
          if (result_o.truncated !== want.truncated) begin
            $error("truncated: expected %0d, got %0d", want.truncated, result_o.truncated);
            fail_count++;
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic queue_beat(input cmd_e c, input logic [SLOT_W-1:0] s,
                            input logic [IN_CHAR_W-1:0] ch);
    item_t it;
    it.cmd        = c;
    it.slot       = s;
    it.char_value = ch;
    stim_items = {stim_items, it};
    items_added++;
  endtask

  function automatic logic [IN_CHAR_W-1:0] pick_char();
    logic [IN_CHAR_W-1:0] edges[8] = '{16'h40, 16'h41, 16'h5A, 16'h5B,
                                       16'h60, 16'h61, 16'h7A, 16'h7B};
    int r;
    r = $urandom_range(15);
    if (r <= 5) return IN_CHAR_W'(16'h61 + $urandom_range(2));
    if (r <= 8) return IN_CHAR_W'(16'h41 + $urandom_range(2));
    if (r == 9) return IN_CHAR_W'(CH_SLASH);
    if (r == 10) return IN_CHAR_W'(CH_BACKSLASH);
    if (r == 11) return IN_CHAR_W'(CH_STAR);
    if (r == 12) return IN_CHAR_W'(CH_QUESTION);
    if (r == 13) return IN_CHAR_W'($urandom);
    if (r == 14) return edges[$urandom_range(7)];
    return $urandom_range(1) ? 16'hFFFF : 16'h0000;
  endfunction

  function automatic logic [IN_CHAR_W-1:0] flip_case(input logic [IN_CHAR_W-1:0] c);
    if ((c >= 16'h41 && c <= 16'h5A) || (c >= 16'h61 && c <= 16'h7A)) return c ^ 16'h20;
    return c;
  endfunction

  // pattern built from the path so that a fair share of paths match
  task automatic derive_pattern(input logic [SLOT_W-1:0] s, input logic [IN_CHAR_W-1:0] path[$]);
    int r;
    foreach (path[k]) begin
      r = $urandom_range(9);
      case (r)
        0: queue_beat(CMD_APPEND, s, IN_CHAR_W'(CH_QUESTION));
        1: queue_beat(CMD_APPEND, s, IN_CHAR_W'(CH_STAR));
        2: begin
          queue_beat(CMD_APPEND, s, IN_CHAR_W'(CH_STAR));
          queue_beat(CMD_APPEND, s, path[k]);
        end
        3: queue_beat(CMD_APPEND, s, flip_case(path[k]));
        4: queue_beat(CMD_APPEND, s, pick_char());
        default: queue_beat(CMD_APPEND, s, path[k]);
      endcase
    end
    if ($urandom_range(3) == 0) queue_beat(CMD_APPEND, s, IN_CHAR_W'(CH_STAR));
  endtask

  task automatic gen_round();
    logic [IN_CHAR_W-1:0] path[$];
    logic [SLOT_W-1:0]    s;
    int                   plen;
    if ($urandom_range(1) == 0) queue_beat(CMD_CLEAR, SLOT_W'($urandom), IN_CHAR_W'($urandom));
    plen = $urandom_range(0, 8);
    for (int k = 0; k < plen; k++) path = {path, pick_char()};
    for (int j = $urandom_range(1, 3); j > 0; j--) begin
      s = SLOT_W'($urandom_range(7));
      derive_pattern(s, path);
    end
    if ($urandom_range(19) == 0) begin
      s = SLOT_W'($urandom_range(7));
      for (int k = $urandom_range(60, 70); k > 0; k--) queue_beat(CMD_APPEND, s, pick_char());
    end
    foreach (path[k]) begin
      if ($urandom_range(29) == 0) begin
        queue_beat(cmd_e'($urandom_range(3)), SLOT_W'($urandom), IN_CHAR_W'($urandom));
      end
      queue_beat(CMD_PATH, SLOT_W'($urandom), path[k]);
    end
    queue_beat(CMD_END, SLOT_W'($urandom), IN_CHAR_W'($urandom));
  endtask

  task automatic wait_drained();
    while (stim_items.size() != 0 || push || expected_verdicts.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int idle_tab[4]  = '{0, 45, 0, 17};
    int stall_tab[4] = '{0, 0, 45, 17};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: case folding, slash storage, extreme codes, empty path and clear
    queue_beat(CMD_CLEAR, 3'd0, 16'h0000);
    queue_beat(CMD_APPEND, 3'd0, 16'h41);
    queue_beat(CMD_APPEND, 3'd0, IN_CHAR_W'(CH_STAR));
    queue_beat(CMD_APPEND, 3'd0, 16'h43);
    queue_beat(CMD_APPEND, 3'd3, IN_CHAR_W'(CH_QUESTION));
    queue_beat(CMD_APPEND, 3'd3, IN_CHAR_W'(CH_SLASH));
    queue_beat(CMD_APPEND, 3'd7, 16'hFFFF);
    queue_beat(CMD_APPEND, 3'd7, 16'h0000);
    queue_beat(CMD_PATH, 3'd0, 16'h61);
    queue_beat(CMD_PATH, 3'd0, 16'h78);
    queue_beat(CMD_PATH, 3'd0, 16'h63);
    queue_beat(CMD_END, 3'd0, 16'h0000);
    queue_beat(CMD_PATH, 3'd7, 16'h51);
    queue_beat(CMD_PATH, 3'd7, IN_CHAR_W'(CH_BACKSLASH));
    queue_beat(CMD_END, 3'd7, 16'hFFFF);
    queue_beat(CMD_PATH, 3'd5, 16'h71);
    queue_beat(CMD_PATH, 3'd5, IN_CHAR_W'(CH_SLASH));
    queue_beat(CMD_END, 3'd5, 16'h0000);
    queue_beat(CMD_PATH, 3'd2, 16'hFFFF);
    queue_beat(CMD_PATH, 3'd2, 16'h0000);
    queue_beat(CMD_END, 3'd2, 16'h0000);
    queue_beat(CMD_END, 3'd1, 16'h0000);
    queue_beat(CMD_CLEAR, 3'd7, 16'hFFFF);
    queue_beat(CMD_END, 3'd4, 16'h1234);

    for (int p = 0; p < 4; p++) begin
      wait_drained();
      send_idle_pct  = idle_tab[p];
      recv_stall_pct = stall_tab[p];
      items_added    = 0;
      while (items_added < PHASE_ITEMS) gen_round();
    end
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/mpwm_pkg.sv
src/mpwm_front.sv
src/mpwm_engine.sv
src/multi_pattern_wildcard_matcher.sv
tb/tb_multi_pattern_wildcard_matcher.sv
